@@ rtl/hbd_pkg.sv @@
// Shared types, codes and the CRC-16/X.25 octet update for the HDLC bit deframer.
// No dependencies; used by hbd_front, hbd_back and hdlc_bit_deframer.

package hbd_pkg;

    localparam int LEN_W  = 13;
    localparam int KIND_W = 2;
    localparam int TOK_W  = 2;

    // result kinds
    localparam logic [KIND_W-1:0] KIND_DATA  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_GOOD  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_BAD   = 2'd2;
    localparam logic [KIND_W-1:0] KIND_ABORT = 2'd3;

    // token codes passed from the line classifier to the frame engine
    localparam logic [TOK_W-1:0] TOK_DATA  = 2'd0;
    localparam logic [TOK_W-1:0] TOK_FLAG  = 2'd1;
    localparam logic [TOK_W-1:0] TOK_ABORT = 2'd2;

    // line patterns
    localparam logic [6:0] ABORT_PAT = 7'h7F;
    localparam logic [7:0] FLAG_PAT  = 8'h7E;
    localparam logic [5:0] STUFF_PAT = 6'h3E;

    localparam logic [15:0]      FCS_PRESET  = 16'hFFFF;
    localparam logic [15:0]      FCS_RESIDUE = 16'hF0B8;
    localparam logic [15:0]      FCS_POLY    = 16'h8408;
    localparam logic [LEN_W-1:0] MAX_LEN_RST = 13'd512;

    typedef struct packed {
        logic [TOK_W-1:0] code;
        logic             bit_val;
    } tok_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [7:0]        byte_value;
        logic [LEN_W-1:0]  frame_length;
    } res_t;

    // reflected CRC-16 update over one octet, LSB first
    function automatic logic [15:0] fcs_byte(input logic [15:0] fcs_in,
                                             input logic [7:0] octet);
        logic [15:0] f;
        logic        lsb;
        f = fcs_in;
        for (int k = 0; k < 8; k++)
        begin
            lsb = f[0] ^ octet[k];
            f   = {1'b0, f[15:1]};
            if (lsb)
            begin
                f = f ^ FCS_POLY;
            end
        end
        return f;
    endfunction

endpackage

@@ rtl/hdlc_bit_deframer.sv @@
// Top level of the HDLC bit deframer: length limit register, line front end
// and frame engine. Depends on hbd_pkg, hbd_front, hbd_back.
//
//  channel   ports                              beat
//  line in   push, full, bit_in                 one line bit
//  results   empty, pop, kind, byte_value,      one octet or frame event
//            frame_length
//  config    cfg_we, cfg_data                   max_frame_len write
//
// One line bit is taken per clock while full is low. An accepted bit goes
// through the line classifier into the token queue, then through the frame engine
// with the octet CRC into the result queue, from which its result can be popped.
// Reset leaves the block hunting for a flag with a limit of 512 octets.
// Two-beat queues after each part let either side stall; the line side sees
// full only when the result side has stopped popping.

module hdlc_bit_deframer
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      push,
    output logic                      full,
    input  logic                      bit_in,
    output logic                      empty,
    input  logic                      pop,
    output logic [1:0]                kind,
    output logic [7:0]                byte_value,
    output logic [hbd_pkg::LEN_W-1:0] frame_length,
    input  logic                      cfg_we,
    input  logic [hbd_pkg::LEN_W-1:0] cfg_data
);

    logic [hbd_pkg::LEN_W-1:0] max_len_reg;
    logic                      tok_valid;
    hbd_pkg::tok_t             tok;
    logic                      tok_take;
    hbd_pkg::res_t             res;

    // length limit register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_len_reg <= hbd_pkg::MAX_LEN_RST;
        end
        else if (cfg_we)
        begin
            max_len_reg <= cfg_data;
        end
    end

    hbd_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .bit_in    (bit_in),
        .full      (full),
        .tok_valid (tok_valid),
        .tok       (tok),
        .tok_take  (tok_take)
    );

    hbd_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .max_len   (max_len_reg),
        .tok_valid (tok_valid),
        .tok       (tok),
        .tok_take  (tok_take),
        .res       (res),
        .empty     (empty),
        .pop       (pop)
    );

    assign kind         = res.kind;
    assign byte_value   = res.byte_value;
    assign frame_length = res.frame_length;

endmodule

@@ rtl/hbd_front.sv @@
// Line front end: keeps the last eight line bits, classifies each bit as
// abort, flag, stuffed zero or data, and queues tokens. Depends on hbd_pkg.

module hbd_front
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  logic          bit_in,
    output logic          full,
    output logic          tok_valid,
    output hbd_pkg::tok_t tok,
    input  logic          tok_take
);

    logic [7:0]    recent_reg;
    logic [7:0]    recent_next;
    hbd_pkg::tok_t q_mem [2];
    logic          wr_ptr_reg;
    logic          rd_ptr_reg;
    logic [1:0]    count_reg;
    logic          accept;
    logic          drop;
    hbd_pkg::tok_t new_tok;
    logic          do_wr;
    logic          do_rd;

    assign accept      = push && !full;
    assign recent_next = {recent_reg[6:0], bit_in};

    // classify the bit in priority order: abort, flag, stuffed zero, data
    always_comb
    begin
        drop            = 1'b0;
        new_tok.bit_val = bit_in;
        priority if (recent_next[6:0] == hbd_pkg::ABORT_PAT)
        begin
            new_tok.code = hbd_pkg::TOK_ABORT;
        end
        else if (recent_next == hbd_pkg::FLAG_PAT)
        begin
            new_tok.code = hbd_pkg::TOK_FLAG;
        end
        else if (recent_next[5:0] == hbd_pkg::STUFF_PAT)
        begin
            new_tok.code = hbd_pkg::TOK_DATA;
            drop         = 1'b1;
        end
        else
        begin
            new_tok.code = hbd_pkg::TOK_DATA;
        end
    end

    assign do_wr     = accept && !drop;
    assign do_rd     = tok_take && tok_valid;
    assign full      = (count_reg == 2'd2);
    assign tok_valid = (count_reg != 2'd0);
    assign tok       = q_mem[rd_ptr_reg];

    // line history and queue pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            recent_reg <= 8'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (accept)
            begin
                recent_reg <= recent_next;
            end
            if (do_wr)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_reg + {1'b0, do_wr} - {1'b0, do_rd};
        end
    end

    // token storage
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            q_mem[wr_ptr_reg] <= new_tok;
        end
    end

endmodule

@@ rtl/hbd_back.sv @@
// Frame engine: packs octets, runs the FCS, holds two octets back and reports
// data octets and frame ends into a two-beat result queue. Depends on hbd_pkg.

module hbd_back
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [hbd_pkg::LEN_W-1:0]  max_len,
    input  logic                       tok_valid,
    input  hbd_pkg::tok_t              tok,
    output logic                       tok_take,
    output hbd_pkg::res_t              res,
    output logic                       empty,
    input  logic                       pop
);

    logic                      in_frame_reg, in_frame_next;
    logic [2:0]                bit_cnt_reg, bit_cnt_next;
    logic [7:0]                shift_reg, shift_next;
    logic [7:0]                held0_reg, held0_next;
    logic [7:0]                held1_reg, held1_next;
    logic [1:0]                held_cnt_reg, held_cnt_next;
    logic [hbd_pkg::LEN_W-1:0] flc_reg, flc_next;
    logic [15:0]               fcs_reg, fcs_next;

    logic                      emit;
    hbd_pkg::res_t             emit_res;
    logic [7:0]                octet;
    logic [hbd_pkg::LEN_W-1:0] streamed;
    logic                      long_enough;

    hbd_pkg::res_t             r_mem [2];
    logic                      wr_ptr_reg;
    logic                      rd_ptr_reg;
    logic [1:0]                r_cnt_reg;
    logic                      do_rd;

    // take a token whenever the result queue has room
    assign tok_take    = tok_valid && (r_cnt_reg != 2'd2);
    assign octet       = {tok.bit_val, shift_reg[7:1]};
    assign streamed    = (flc_reg >= 13'd2) ? flc_reg - 13'd2 : '0;
    assign long_enough = in_frame_reg && (flc_reg >= 13'd3);

    // frame state update for one token
    always_comb
    begin
        in_frame_next = in_frame_reg;
        bit_cnt_next  = bit_cnt_reg;
        shift_next    = shift_reg;
        held0_next    = held0_reg;
        held1_next    = held1_reg;
        held_cnt_next = held_cnt_reg;
        flc_next      = flc_reg;
        fcs_next      = fcs_reg;
        emit          = 1'b0;
        emit_res      = '0;
        if (tok_take)
        begin
            unique case (tok.code)
                hbd_pkg::TOK_ABORT:
                begin
                    in_frame_next = 1'b0;
                    if (long_enough)
                    begin
                        emit                  = 1'b1;
                        emit_res.kind         = hbd_pkg::KIND_ABORT;
                        emit_res.frame_length = streamed;
                    end
                end
                hbd_pkg::TOK_FLAG:
                begin
                    if (long_enough)
                    begin
                        emit                  = 1'b1;
                        emit_res.frame_length = streamed;
                        if ((flc_reg >= 13'd4) && (bit_cnt_reg == 3'd7)
                            && (fcs_reg == hbd_pkg::FCS_RESIDUE))
                        begin
                            emit_res.kind = hbd_pkg::KIND_GOOD;
                        end
                        else
                        begin
                            emit_res.kind = hbd_pkg::KIND_BAD;
                        end
                    end
                    // every flag opens a new frame
                    in_frame_next = 1'b1;
                    bit_cnt_next  = 3'd0;
                    shift_next    = 8'd0;
                    held0_next    = 8'd0;
                    held1_next    = 8'd0;
                    held_cnt_next = 2'd0;
                    flc_next      = '0;
                    fcs_next      = hbd_pkg::FCS_PRESET;
                end
                hbd_pkg::TOK_DATA:
                begin
                    if (in_frame_reg)
                    begin
                        shift_next = octet;
                        if (bit_cnt_reg != 3'd7)
                        begin
                            bit_cnt_next = bit_cnt_reg + 3'd1;
                        end
                        else
                        begin
                            bit_cnt_next = 3'd0;
                            if (flc_reg >= max_len)
                            begin
                                // length limit hit: abandon the frame
                                in_frame_next         = 1'b0;
                                emit                  = 1'b1;
                                emit_res.kind         = hbd_pkg::KIND_ABORT;
                                emit_res.frame_length = streamed;
                            end
                            else
                            begin
                                flc_next = flc_reg + 13'd1;
                                fcs_next = hbd_pkg::fcs_byte(fcs_reg, octet);
                                if (held_cnt_reg == 2'd2)
                                begin
                                    emit                = 1'b1;
                                    emit_res.kind       = hbd_pkg::KIND_DATA;
                                    emit_res.byte_value = held0_reg;
                                    held0_next          = held1_reg;
                                    held1_next          = octet;
                                end
                                else if (held_cnt_reg == 2'd0)
                                begin
                                    held0_next    = octet;
                                    held_cnt_next = 2'd1;
                                end
                                else
                                begin
                                    held1_next    = octet;
                                    held_cnt_next = 2'd2;
                                end
                            end
                        end
                    end
                end
                default:
                begin
                    in_frame_next = in_frame_reg;
                end
            endcase
        end
    end

    // frame control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg <= 1'b0;
            bit_cnt_reg  <= 3'd0;
            held_cnt_reg <= 2'd0;
            flc_reg      <= '0;
            fcs_reg      <= hbd_pkg::FCS_PRESET;
            shift_reg    <= 8'd0;
            held0_reg    <= 8'd0;
            held1_reg    <= 8'd0;
        end
        else
        begin
            in_frame_reg <= in_frame_next;
            bit_cnt_reg  <= bit_cnt_next;
            held_cnt_reg <= held_cnt_next;
            flc_reg      <= flc_next;
            fcs_reg      <= fcs_next;
            shift_reg    <= shift_next;
            held0_reg    <= held0_next;
            held1_reg    <= held1_next;
        end
    end

    // result queue
    assign empty = (r_cnt_reg == 2'd0);
    assign do_rd = pop && !empty;
    assign res   = r_mem[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            r_cnt_reg  <= 2'd0;
        end
        else
        begin
            if (emit)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            r_cnt_reg <= r_cnt_reg + {1'b0, emit} - {1'b0, do_rd};
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            r_mem[wr_ptr_reg] <= emit_res;
        end
    end

endmodule

@@ tb/tb_hdlc_bit_deframer.sv @@
// Self-checking bench for hdlc_bit_deframer: builds HDLC line bit streams and
// checks every output beat against an in-bench deframer with CRC-16/X.25.
// Depends on hbd_pkg and the hdlc_bit_deframer RTL.

module tb_hdlc_bit_deframer;

    import hbd_pkg::*;

    localparam int TAIL_CYCLES  = 8;
    localparam int LIMIT_CYCLES = 400000;

    typedef enum int { FLAW_NONE, FLAW_BAD_FCS, FLAW_SKEW, FLAW_ABORT } frame_flaw_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [7:0]        octet;
        logic [LEN_W-1:0]  len;
    } line_event_t;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             push = 1'b0;
    logic             full;
    logic             bit_in = 1'b0;
    logic             empty;
    logic             pop = 1'b0;
    logic [1:0]       kind;
    logic [7:0]       byte_value;
    logic [LEN_W-1:0] frame_length;
    logic             cfg_we = 1'b0;
    logic [LEN_W-1:0] cfg_data = '0;

    // line bits waiting for the driver, and events the deframer must produce
    bit          line_bits[$];
    line_event_t due_events[$];
    int          fail_count = 0;
    int          cycle_count = 0;

    // generator bookkeeping
    int gen_bits = 0;
    int ones_run = 0;
    bit closed_by_flag = 1'b0;

    // in-bench deframer state
    logic [7:0]       hist_bits;
    bit               framing;
    logic [2:0]       bit_pos;
    logic [7:0]       octet_acc;
    logic [7:0]       hold_q [2];
    logic [1:0]       hold_cnt;
    logic [LEN_W-1:0] octet_cnt;
    logic [15:0]      crc_acc;
    logic [LEN_W-1:0] len_limit;

    // driver / receiver pacing
    int          gap_left;
    int          burst_left;
    logic [15:0] pop_pat;
    int          pat_age;

    hdlc_bit_deframer u_dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .bit_in       (bit_in),
        .empty        (empty),
        .pop          (pop),
        .kind         (kind),
        .byte_value   (byte_value),
        .frame_length (frame_length),
        .cfg_we       (cfg_we),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // reflected CRC-16/X.25 over one octet
    function automatic logic [15:0] crc_x25_octet(input logic [15:0] crc,
                                                  input logic [7:0] octet);
        logic [15:0] x;
        x = crc ^ {8'h00, octet};
        repeat (8)
        begin
            x = x[0] ? ((x >> 1) ^ FCS_POLY) : (x >> 1);
        end
        return x;
    endfunction

    function automatic logic [LEN_W-1:0] streamed_octets();
        return (octet_cnt >= 13'd2) ? octet_cnt - 13'd2 : '0;
    endfunction

    task automatic queue_event(input logic [KIND_W-1:0] k, input logic [7:0] v,
                               input logic [LEN_W-1:0] n);
        line_event_t ev;
        ev.kind  = k;
        ev.octet = v;
        ev.len   = n;
        due_events.push_back(ev);
    endtask

    task automatic start_frame();
        framing   = 1'b1;
        bit_pos   = '0;
        octet_acc = '0;
        hold_q[0] = '0;
        hold_q[1] = '0;
        hold_cnt  = '0;
        octet_cnt = '0;
        crc_acc   = FCS_PRESET;
    endtask

    task automatic reset_deframer();
        hist_bits = '0;
        len_limit = MAX_LEN_RST;
        start_frame();
        framing = 1'b0;
    endtask

    // predicts what one accepted line bit produces
    task automatic deframe_bit(input logic b);
        logic good;
        hist_bits = {hist_bits[6:0], b};
        // seven ones: abort, back to hunting
        if (hist_bits[6:0] == ABORT_PAT)
        begin
            if (framing && octet_cnt >= 3)
            begin
                queue_event(KIND_ABORT, 8'h00, streamed_octets());
            end
            framing = 1'b0;
            return;
        end
        // flag closes the current frame and opens another
        if (hist_bits == FLAG_PAT)
        begin
            if (framing && octet_cnt >= 3)
            begin
                good = (octet_cnt >= 4) && (bit_pos == 3'd7) && (crc_acc == FCS_RESIDUE);
                queue_event(good ? KIND_GOOD : KIND_BAD, 8'h00, streamed_octets());
            end
            start_frame();
            return;
        end
        // stuffed zero after five ones
        if (hist_bits[5:0] == STUFF_PAT || !framing)
        begin
            return;
        end
        octet_acc = {b, octet_acc[7:1]};
        if (bit_pos != 3'd7)
        begin
            bit_pos = bit_pos + 3'd1;
            return;
        end
        bit_pos = '0;
        // length limit reached: abandon the frame
        if (octet_cnt >= len_limit)
        begin
            queue_event(KIND_ABORT, 8'h00, streamed_octets());
            framing = 1'b0;
            return;
        end
        octet_cnt = octet_cnt + 1'b1;
        crc_acc   = crc_x25_octet(crc_acc, octet_acc);
        // two-octet hold keeps the FCS from being streamed
        if (hold_cnt >= 2)
        begin
            queue_event(KIND_DATA, hold_q[0], '0);
            hold_q[0] = hold_q[1];
            hold_q[1] = octet_acc;
        end
        else
        begin
            hold_q[hold_cnt[0]] = octet_acc;
            hold_cnt = hold_cnt + 2'd1;
        end
    endtask

    // ---------------- line stream generation ----------------

    task automatic add_line_bit(input bit b);
        line_bits.push_back(b);
        gen_bits++;
    endtask

    task automatic put_raw_octet(input logic [7:0] o);
        for (int i = 0; i < 8; i++)
        begin
            add_line_bit(o[i]);
        end
        ones_run = 0;
    endtask

    task automatic put_flag();
        put_raw_octet(FLAG_PAT);
        closed_by_flag = 1'b1;
    endtask

    task automatic put_abort();
        repeat ($urandom_range(7, 12))
        begin
            add_line_bit(1'b1);
        end
        ones_run = 0;
        closed_by_flag = 1'b0;
    endtask

    // data bit with zero insertion after five ones
    task automatic put_data_bit(input bit b);
        add_line_bit(b);
        ones_run = b ? ones_run + 1 : 0;
        if (ones_run == 5)
        begin
            add_line_bit(1'b0);
            ones_run = 0;
        end
    endtask

    task automatic put_data_octet(input logic [7:0] o);
        for (int i = 0; i < 8; i++)
        begin
            put_data_bit(o[i]);
        end
    endtask

    task automatic put_noise();
        repeat ($urandom_range(1, 30))
        begin
            add_line_bit($urandom_range(0, 3) != 0);
        end
        ones_run = 0;
        closed_by_flag = 1'b0;
    endtask

    function automatic logic [7:0] pick_octet();
        case ($urandom_range(0, 7))
            0: return 8'hFF;
            1: return 8'h00;
            2: return FLAG_PAT;
            3: return 8'h3F;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic int pick_payload_len();
        if (len_limit <= 24)
        begin
            return $urandom_range(0, len_limit);
        end
        if ($urandom_range(0, 9) == 0)
        begin
            return $urandom_range(0, 40);
        end
        return $urandom_range(0, 14);
    endfunction

    task automatic put_frame(input int n_payload, input frame_flaw_t flaw);
        logic [15:0] crc;
        logic [7:0]  octet;
        int          cut;
        crc = FCS_PRESET;
        cut = $urandom_range(0, n_payload + 1);
        // a closing flag may double as the next opening flag
        if (!closed_by_flag || $urandom_range(0, 1))
        begin
            put_flag();
        end
        closed_by_flag = 1'b0;
        for (int i = 0; i < n_payload; i++)
        begin
            if (flaw == FLAW_ABORT && i == cut)
            begin
                put_abort();
                return;
            end
            octet = pick_octet();
            crc   = crc_x25_octet(crc, octet);
            put_data_octet(octet);
        end
        crc = ~crc;
        if (flaw == FLAW_BAD_FCS)
        begin
            crc = crc ^ (16'h0001 << $urandom_range(0, 15));
        end
        put_data_octet(crc[7:0]);
        put_data_octet(crc[15:8]);
        if (flaw == FLAW_ABORT)
        begin
            put_abort();
            return;
        end
        if (flaw == FLAW_SKEW)
        begin
            repeat ($urandom_range(1, 7))
            begin
                put_data_bit(1'($urandom_range(0, 1)));
            end
        end
        put_flag();
    endtask

    // mostly well-formed frames, the rest broken frames, line noise and runs of flags
    task automatic fill_random(input int n_bits);
        int start;
        int r;
        start = gen_bits;
        while (gen_bits - start < n_bits)
        begin
            r = $urandom_range(0, 99);
            if (r < 60)
                put_frame(pick_payload_len(), FLAW_NONE);
            else if (r < 70)
                put_frame(pick_payload_len(), FLAW_BAD_FCS);
            else if (r < 78)
                put_frame(pick_payload_len(), FLAW_SKEW);
            else if (r < 86)
                put_frame(pick_payload_len(), FLAW_ABORT);
            else if (r < 94)
                put_noise();
            else
                repeat ($urandom_range(1, 3)) put_flag();
        end
    endtask

    // waits until every line bit is taken and every event has come out
    task automatic wait_drained();
        @(negedge clk);
        while (line_bits.size() != 0 || push || due_events.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (TAIL_CYCLES) @(negedge clk);
    endtask

    task automatic write_limit(input logic [LEN_W-1:0] v);
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
        len_limit = v;
        @(negedge clk);
    endtask

    task automatic run_phase(input logic [LEN_W-1:0] limit, input int n_bits);
        wait_drained();
        write_limit(limit);
        fill_random(n_bits);
    endtask

    // ---------------- sequence ----------------

    initial
    begin
        reset_deframer();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: short frame with a stuffed octet, abort while framing, flags
        put_flag();
        put_data_octet(8'hFF);
        put_flag();
        put_abort();
        fill_random(250);

        run_phase(13'd4096, 250);
        run_phase(13'd4, 220);
        run_phase(13'($urandom_range(5, 16)), 220);
        run_phase(13'($urandom_range(17, 4096)), 220);
        run_phase(MAX_LEN_RST, 220);
        run_phase(13'd7, 220);

        wait_drained();
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // line side: one bit per beat, bursts with random gaps
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            push       <= 1'b0;
            bit_in     <= 1'b0;
            gap_left   = 0;
            burst_left = 0;
        end
        else
        begin
            if (push && !full)
            begin
                deframe_bit(bit_in);
            end
            if (!push || !full)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    push <= 1'b0;
                end
                else if (line_bits.size() > 0)
                begin
                    push   <= 1'b1;
                    bit_in <= line_bits.pop_front();
                    if (burst_left > 0)
                    begin
                        burst_left--;
                    end
                    else
                    begin
                        burst_left = $urandom_range(1, 48);
                        case ($urandom_range(0, 9))
                            0, 1, 2: gap_left = 0;
                            8, 9:    gap_left = $urandom_range(4, 20);
                            default: gap_left = $urandom_range(1, 3);
                        endcase
                    end
                end
                else
                begin
                    push <= 1'b0;
                end
            end
        end
    end

    // result side: pop on a rotating pattern, check each beat
    always @(posedge clk or negedge rst_n)
    begin
        line_event_t ev;
        if (!rst_n)
        begin
            pop     <= 1'b0;
            pop_pat = 16'hFFFF;
            pat_age = 0;
        end
        else
        begin
            if (pop && !empty)
            begin
                if (due_events.size() == 0)
                begin
                    $error("unexpected beat: kind %0d byte_value %0h frame_length %0d",
                           kind, byte_value, frame_length);
                    fail_count++;
                end
                else
                begin
                    ev = due_events.pop_front();
                    if (kind !== ev.kind)
                    begin
                        $error("kind: expected %0d, got %0d", ev.kind, kind);
                        fail_count++;
                    end
                    if (byte_value !== ev.octet)
                    begin
                        $error("byte_value: expected %0h, got %0h", ev.octet, byte_value);
                        fail_count++;
                    end
                    if (frame_length !== ev.len)
                    begin
                        $error("frame_length: expected %0d, got %0d", ev.len, frame_length);
                        fail_count++;
                    end
                end
            end
            pat_age++;
            if (pat_age == 48)
            begin
                pat_age = 0;
                case ($urandom_range(0, 3))
                    0: pop_pat = 16'hFFFF;
                    1: pop_pat = 16'($urandom);
                    2: pop_pat = 16'h0001 << $urandom_range(0, 15);
                    default: pop_pat = 16'($urandom | $urandom);
                endcase
                if (pop_pat == '0)
                begin
                    pop_pat = 16'h0001;
                end
            end
            pop_pat = {pop_pat[0], pop_pat[15:1]};
            pop <= pop_pat[0];
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

endmodule
